// ===== rtl/scom_pkg.sv =====
// shared types and constants for the scan curvature / occlusion marker
// no dependencies; imported by scom_window and scan_curvature_occlusion_marker
`default_nettype none

package scom_pkg;

  // fixed field widths
  localparam int RANGE_W         = 24;
  localparam int COL_W           = 12;
  localparam int BEAM_W          = 16;
  localparam int RANGE_FRAC_BITS = 8;

  // window geometry
  localparam int WIN   = 12;  // range and mark window depth
  localparam int FWIN  = 7;   // finite window depth, also points needed for pair checks
  localparam int DELAY = 6;   // output delay in points

  // point position wraps at a power of two
  localparam int MAX_POINTS = 65536;
  localparam int PC_W       = $clog2(MAX_POINTS);

  localparam int SEEN_W = $clog2(WIN + 1);
  localparam int K_W    = $clog2(DELAY + 1);
  localparam int SUM_W  = RANGE_W + $clog2(WIN);
  localparam int CURV_W = 2 * SUM_W;

  // stream packing
  localparam int IN_DATA_W  = ((RANGE_W + COL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = PC_W + CURV_W;
  localparam int OUT_USER_W = 3;

  // config port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam logic [RANGE_W-1:0] OCC_GAP_RESET =
    RANGE_W'(((3 << RANGE_FRAC_BITS) + 9) / 10);
  localparam logic [BEAM_W-1:0]  BEAM_RATIO_RESET = BEAM_W'(1311);
  localparam logic [COL_W-1:0]   COL_GAP_RESET    = COL_W'(10);

  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [SUM_W-1:0]   sum_t;

  typedef enum logic [1:0] {
    REG_OCC_GAP    = 2'd0,
    REG_BEAM_RATIO = 2'd1,
    REG_COL_GAP    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [RANGE_W-1:0] occlusion_gap;
    logic [BEAM_W-1:0]  beam_ratio;
    logic [COL_W-1:0]   column_gap_limit;
  } cfg_t;

  // what the result stage needs to see of the window after an update
  typedef struct packed {
    range_t              rw_first;   // oldest slot
    range_t              rw_ctr_a;   // centre for the delayed point
    range_t              rw_ctr_b;   // centre one point newer
    range_t              rw_newest;  // newest slot
    sum_t                total;      // sum of all window slots
    logic [DELAY:0]      marks;      // mark slots 0..6
    logic                fin_oldest;
    logic [SEEN_W-1:0]   seen;
    logic [PC_W-1:0]     pc;
    logic                scan_done;  // newest point closed its scan
  } win_view_t;

endpackage

`default_nettype wire

// ===== rtl/scom_window.sv =====
// sliding point window: range, column, finite and mark slots, running sum
// depends on scom_pkg
`default_nettype none

module scom_window (
  input  logic                clk,
  input  logic                rst,
  input  scom_pkg::cfg_t      cfg,
  input  logic                accept,
  input  scom_pkg::range_t    in_range,
  input  logic [11:0]         in_column,
  input  logic                in_finite,
  input  logic                in_last,
  output scom_pkg::win_view_t view
);
  import scom_pkg::*;

  range_t             rw [WIN];
  logic [COL_W-1:0]   col_prev;
  logic [FWIN-1:0]    fin;
  logic [WIN-1:0]     mk;
  logic [PC_W-1:0]    pc;
  logic [SEEN_W-1:0]  seen;
  logic               scan_done;
  sum_t               total;

  logic [SEEN_W-1:0]  seen_e, seen_next;
  logic [PC_W-1:0]    pc_e, pc_next;
  logic [WIN-1:0]     mk_e, mk_next;
  range_t             d0, d1, d2, diff_l, diff_r;
  logic [COL_W-1:0]   col_diff;
  logic [BEAM_W+RANGE_W-1:0] lim, dev_l, dev_r;
  logic               step_down, step_up, adjacent, beam, check;

  // a finished scan reads as cleared for the next point
  assign seen_e = scan_done ? '0 : seen;
  assign pc_e   = scan_done ? '0 : pc;
  assign mk_e   = scan_done ? '0 : mk;

  assign seen_next = (seen_e < SEEN_W'(WIN)) ? seen_e + 1'b1 : seen_e;
  assign pc_next   = (seen_e != '0) ? pc_e + 1'b1 : pc_e;
  assign check     = seen_next >= SEEN_W'(FWIN);

  assign d0 = rw[WIN-2];
  assign d1 = rw[WIN-1];
  assign d2 = in_range;

  assign diff_l   = (d0 > d1) ? d0 - d1 : d1 - d0;
  assign diff_r   = (d2 > d1) ? d2 - d1 : d1 - d2;
  assign col_diff = (in_column > col_prev) ? in_column - col_prev : col_prev - in_column;

  assign step_down = (d1 > d2) && ((d1 - d2) > cfg.occlusion_gap);
  assign step_up   = (d2 > d1) && ((d2 - d1) > cfg.occlusion_gap);
  assign adjacent  = col_diff < cfg.column_gap_limit;

  assign lim   = cfg.beam_ratio * d1;
  assign dev_l = {diff_l, {BEAM_W{1'b0}}};
  assign dev_r = {diff_r, {BEAM_W{1'b0}}};
  assign beam  = (dev_l > lim) && (dev_r > lim);

  always_comb begin
    mk_next = {1'b0, mk_e[WIN-1:1]};
    if (check) begin
      if (adjacent && step_down) begin
        mk_next[DELAY-1:0] = '1;
      end else if (adjacent && step_up) begin
        mk_next[WIN-1:DELAY] = '1;
      end
      if (beam) begin
        mk_next[DELAY-1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      pc        <= '0;
      scan_done <= 1'b0;
      mk        <= '0;
      total     <= '0;
      col_prev  <= '0;
      fin       <= '0;
      for (int s = 0; s < WIN; s++) begin
        rw[s] <= '0;
      end
    end else if (accept) begin
      seen      <= seen_next;
      pc        <= pc_next;
      scan_done <= in_last;
      mk        <= mk_next;
      total     <= total - SUM_W'(rw[0]) + SUM_W'(in_range);
      for (int s = 0; s < WIN - 1; s++) begin
        rw[s] <= rw[s+1];
      end
      rw[WIN-1] <= in_range;
      col_prev  <= in_column;
      fin       <= {in_finite, fin[FWIN-1:1]};
    end
  end

  assign view.rw_first   = rw[0];
  assign view.rw_ctr_a   = rw[DELAY-1];
  assign view.rw_ctr_b   = rw[DELAY];
  assign view.rw_newest  = rw[WIN-1];
  assign view.total      = total;
  assign view.marks      = mk[DELAY:0];
  assign view.fin_oldest = fin[0];
  assign view.seen       = seen;
  assign view.pc         = pc;
  assign view.scan_done  = scan_done;

endmodule

`default_nettype wire

// ===== rtl/scan_curvature_occlusion_marker.sv =====
// top level: stream ports, config registers, curvature and result sequencing
// depends on scom_pkg and scom_window
`default_nettype none

// Lidar point curvature and occlusion marker. One point word per cycle is taken
// on the slave stream unless stalled; each point comes back out six points later
// carrying its 11-tap curvature, curvature_valid, marked and good flags. A word
// with tlast set closes the scan: the remaining delayed points (up to seven
// results in all) are flushed out one per cycle while the output is free, the
// last of them with tlast. Normal points sustain one word per cycle while the
// output is free; a scan-closing word holds the result sequencer until its points
// (at most seven) are flushed, and input backs up behind it. A taken word passes
// the window, sequencer and output registers. The user must write the config
// registers only while the block is idle; the block itself does not enforce this.
module scan_curvature_occlusion_marker (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [scom_pkg::IN_DATA_W-1:0]     s_tdata,   // range[23:0], column[35:24]
  input  logic                               s_tuser,   // finite
  input  logic                               s_tlast,
  // master stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [scom_pkg::OUT_DATA_W-1:0]    m_tdata,   // point_index[15:0], curvature[71:16]
  output logic [scom_pkg::OUT_USER_W-1:0]    m_tuser,   // curvature_valid, marked, good
  output logic                               m_tlast,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [scom_pkg::APB_AW-1:0]        paddr,
  input  logic [scom_pkg::APB_DW-1:0]        pwdata,
  output logic [scom_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import scom_pkg::*;

  // config registers
  cfg_t      cfg;
  cfg_reg_e  reg_sel;
  logic      cfg_wr;

  // window stage: the window registers hold the newest accepted point
  win_view_t view;
  logic      in_accept;
  logic      s1_valid, s1_has, s1_adv;

  // result sequencer stage: one job per point that gives results, k counts down the delays
  logic              s2_valid, s2_last, s2_fin;
  logic [K_W-1:0]    s2_k, k_init;
  logic [SEEN_W-1:0] s2_seen;
  logic [PC_W-1:0]   s2_pc;
  sum_t              s2_dd_a, s2_dd_b;
  logic [DELAY:0]    s2_marks;
  logic              s2_load, s2_fire, s2_finish, s2_free;

  // curvature terms read from the window
  sum_t sum_a, sum_b, ten_a, ten_b, dd_a, dd_b;

  // result fields for the current k
  logic              cv, mk, gd;
  sum_t              dd_sel;
  logic [CURV_W-1:0] sq;

  // output register
  logic              s3_free;
  logic [PC_W-1:0]   out_pi;
  logic [CURV_W-1:0] out_curv;
  logic              out_cv, out_marked, out_good, out_last;

  //--------------------------------------------------------------------------
  // config port, zero-wait
  //--------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_OCC_GAP:    prdata = APB_DW'(cfg.occlusion_gap);
      REG_BEAM_RATIO: prdata = APB_DW'(cfg.beam_ratio);
      REG_COL_GAP:    prdata = APB_DW'(cfg.column_gap_limit);
      default:        prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // window update on every accepted word
  //--------------------------------------------------------------------------
  assign in_accept = s_tvalid && s_tready;

  scom_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (in_accept),
    .in_range  (s_tdata[RANGE_W-1:0]),
    .in_column (s_tdata[RANGE_W+COL_W-1:RANGE_W]),
    .in_finite (s_tuser),
    .in_last   (s_tlast),
    .view      (view)
  );

  // a point gives results once the window is deep enough or the scan ends
  assign s1_has = view.scan_done || (view.seen >= SEEN_W'(FWIN));

  // pipeline handshake, back to front
  assign s3_free   = !m_tvalid || m_tready;
  assign s2_fire   = s2_valid && s3_free;
  assign s2_finish = !s2_last || (s2_k == '0);
  assign s2_free   = !s2_valid || (s2_fire && s2_finish);
  assign s2_load   = s1_valid && s1_has && s2_free;
  assign s1_adv    = s1_valid && (!s1_has || s2_free);
  assign s_tready  = !s1_valid || s1_adv;

  //--------------------------------------------------------------------------
  // curvature difference for both possible centres, from the running sum
  //--------------------------------------------------------------------------
  // centre slot 5 spans slots 0..10, centre slot 6 spans slots 1..11
  assign sum_a = view.total - SUM_W'(view.rw_ctr_a) - SUM_W'(view.rw_newest);
  assign sum_b = view.total - SUM_W'(view.rw_first) - SUM_W'(view.rw_ctr_b);
  assign ten_a = SUM_W'({view.rw_ctr_a, 3'b000}) + SUM_W'({view.rw_ctr_a, 1'b0});
  assign ten_b = SUM_W'({view.rw_ctr_b, 3'b000}) + SUM_W'({view.rw_ctr_b, 1'b0});
  assign dd_a  = (sum_a > ten_a) ? sum_a - ten_a : ten_a - sum_a;
  assign dd_b  = (sum_b > ten_b) ? sum_b - ten_b : ten_b - sum_b;

  // a closing word on a short scan starts with its oldest point
  assign k_init = (view.scan_done && (view.seen < SEEN_W'(FWIN)))
                ? K_W'(view.seen - 1'b1) : K_W'(DELAY);

  //--------------------------------------------------------------------------
  // per-result fields; k is the delay of the point being emitted
  //--------------------------------------------------------------------------
  assign cv = ((s2_k == K_W'(DELAY))     && (s2_seen >= SEEN_W'(WIN))) ||
              ((s2_k == K_W'(DELAY - 1)) && (s2_seen >= SEEN_W'(WIN - 1)));
  assign dd_sel = !cv ? '0 : ((s2_k == K_W'(DELAY)) ? s2_dd_a : s2_dd_b);
  assign sq     = dd_sel * dd_sel;
  assign mk     = s2_marks[K_W'(DELAY) - s2_k];
  assign gd     = !mk && s2_fin && (s2_k == K_W'(DELAY)) && (s2_seen >= SEEN_W'(WIN));

  //--------------------------------------------------------------------------
  // control registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
      cfg.occlusion_gap    <= OCC_GAP_RESET;
      cfg.beam_ratio       <= BEAM_RATIO_RESET;
      cfg.column_gap_limit <= COL_GAP_RESET;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (s2_fire && s2_finish) begin
        s2_valid <= 1'b0;
      end

      if (s2_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (reg_sel)
          REG_OCC_GAP:    cfg.occlusion_gap    <= pwdata[RANGE_W-1:0];
          REG_BEAM_RATIO: cfg.beam_ratio       <= pwdata[BEAM_W-1:0];
          REG_COL_GAP:    cfg.column_gap_limit <= pwdata[COL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  //--------------------------------------------------------------------------
  // payload registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_last  <= view.scan_done;
      s2_k     <= k_init;
      s2_seen  <= view.seen;
      s2_pc    <= view.pc;
      s2_dd_a  <= dd_a;
      s2_dd_b  <= dd_b;
      s2_marks <= view.marks;
      s2_fin   <= view.fin_oldest;
    end else if (s2_fire) begin
      s2_k <= s2_k - 1'b1;
    end

    if (s2_fire) begin
      out_pi     <= s2_pc - PC_W'(s2_k);
      out_curv   <= sq;
      out_cv     <= cv;
      out_marked <= mk;
      out_good   <= gd;
      out_last   <= s2_last && (s2_k == '0);
    end
  end

  assign m_tdata = {out_curv, out_pi};
  assign m_tuser = {out_good, out_marked, out_cv};
  assign m_tlast = out_last;

  //--------------------------------------------------------------------------
  // checks
  //--------------------------------------------------------------------------
  // curvature is zero whenever it is flagged not valid
  a_curv_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[OUT_DATA_W-1:PC_W] == '0)
    else $error("curvature nonzero without curvature_valid");

  // a good point has a valid curvature and no mark
  a_good_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[0] && !m_tuser[1])
    else $error("good point marked or without curvature");

  // a job that does not close a scan emits only its delayed point
  a_single_job: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_last |-> s2_k == K_W'(DELAY))
    else $error("sequencer left the delayed point on an open scan");

  // the closing result of a scan is never a good point
  a_last_not_good: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser[2])
    else $error("scan-closing result flagged good");

endmodule

`default_nettype wire
